>>> src/spin_pkg.sv
// ----------------------------------------------------------------------------
// spin_pkg
// Shared types and constants of the sonar ping intensity normalizer.
// ----------------------------------------------------------------------------
package spin_pkg;

    localparam int DEF_MAX_BEARINGS = 1024;
    localparam int DEF_MAX_RANGES   = 4096;
    localparam int DEF_MAX_STRIDE   = 8192;
    localparam int GAIN_BYTES       = 4;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SAMPLE_WIDTH = 3'd0;
    localparam logic [2:0] REG_GAINS        = 3'd1;
    localparam logic [2:0] REG_COMP         = 3'd2;
    localparam logic [2:0] REG_BEARINGS     = 3'd3;
    localparam logic [2:0] REG_RANGES       = 3'd4;
    localparam logic [2:0] REG_STRIDE       = 3'd5;

    localparam logic [1:0] WCODE_8  = 2'd0;
    localparam logic [1:0] WCODE_16 = 2'd1;
    localparam logic [1:0] WCODE_32 = 2'd2;
    localparam logic [1:0] WCODE_NA = 2'd3;

    localparam logic [31:0] UNITY_NORM = 32'h8000_0000;
    localparam logic [33:0] DIV_16     = 34'd257;
    localparam logic [33:0] DIV_32     = 34'd16843009;

    localparam int NDIV_STEPS  = 63;
    localparam int NSQRT_STEPS = 32;
    localparam int SDIV_STEPS  = 1;
    localparam int STEP_W      = 6;

    typedef struct packed {
        logic [1:0]  sample_width_code;
        logic        gains_present;
        logic        gain_compensation_on;
        logic [10:0] beam_count;
        logic [12:0] bin_count;
        logic [13:0] row_stride;
    } cfg_t;

    typedef struct packed {
        logic              accept;
        logic              ndiv_step;
        logic              nsqrt_step;
        logic              norm_load;
        logic              samp_mul;
        logic              sdiv_step;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic start_norm;
        logic start_sample;
        logic out_busy;
    } stat_t;

endpackage

>>> src/sonar_ping_intensity_normalizer_core.sv
// ----------------------------------------------------------------------------
// sonar_ping_intensity_normalizer_core
// Byte-stream sonar ping normalizer with per-row gain compensation.
// ----------------------------------------------------------------------------
// Input channel: one byte of the ping image region per beat (data_byte), with
// frame_start marking byte 0 of row 0. A beat is taken when in_valid is high
// and in_stall is low. Output channel: one beat per bearing sample carrying
// intensity, row_last and frame_last, taken when out_valid is high and
// out_stall is low.
// Gain bytes, sample bytes other than the last and padding are taken in idle.
// The last byte of a sample starts, in order, a 32x32 multiply, a divide by
// the width constant built from shifts and adds, and the output register load.
// The last gain byte with compensation on starts a 63-step restoring divide
// of 2^62 by the gain and a 32-step square root.
// The output register holds one result; while the receiver stalls it, the
// next sample finishes and waits, holding in_stall high.
// Reset clears counters and output valid; registers return to their
// defaults (width 8 bit, no gains, 256 bearings, 512 ranges, stride 260).
// The user must configure through APB while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module sonar_ping_intensity_normalizer_core
#(
    parameter int MAX_BEARINGS = spin_pkg::DEF_MAX_BEARINGS,
    parameter int MAX_RANGES   = spin_pkg::DEF_MAX_RANGES,
    parameter int MAX_STRIDE   = spin_pkg::DEF_MAX_STRIDE
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spin_pkg::ADDR_W-1:0] paddr,
    input  logic [spin_pkg::DATA_W-1:0] pwdata,
    output logic [spin_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        frame_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  intensity,
    output logic                        row_last,
    output logic                        frame_last
);

    spin_pkg::cfg_t  cfg_reg;
    spin_pkg::cmd_t  cmd;
    spin_pkg::stat_t st;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_width_code    <= spin_pkg::WCODE_8;
            cfg_reg.gains_present        <= 1'b0;
            cfg_reg.gain_compensation_on <= 1'b0;
            cfg_reg.beam_count           <= 11'd256;
            cfg_reg.bin_count            <= 13'd512;
            cfg_reg.row_stride           <= 14'd260;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                spin_pkg::REG_SAMPLE_WIDTH: cfg_reg.sample_width_code    <= pwdata[1:0];
                spin_pkg::REG_GAINS:        cfg_reg.gains_present        <= pwdata[0];
                spin_pkg::REG_COMP:         cfg_reg.gain_compensation_on <= pwdata[0];
                spin_pkg::REG_BEARINGS:     cfg_reg.beam_count           <= pwdata[10:0];
                spin_pkg::REG_RANGES:       cfg_reg.bin_count            <= pwdata[12:0];
                spin_pkg::REG_STRIDE:       cfg_reg.row_stride           <= pwdata[13:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            spin_pkg::REG_SAMPLE_WIDTH: prdata = 32'(cfg_reg.sample_width_code);
            spin_pkg::REG_GAINS:        prdata = 32'(cfg_reg.gains_present);
            spin_pkg::REG_COMP:         prdata = 32'(cfg_reg.gain_compensation_on);
            spin_pkg::REG_BEARINGS:     prdata = 32'(cfg_reg.beam_count);
            spin_pkg::REG_RANGES:       prdata = 32'(cfg_reg.bin_count);
            spin_pkg::REG_STRIDE:       prdata = 32'(cfg_reg.row_stride);
            default:                    prdata = '0;
        endcase
    end

    spin_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    spin_dp
    #(
        .MAX_BEARINGS (MAX_BEARINGS),
        .MAX_RANGES   (MAX_RANGES),
        .MAX_STRIDE   (MAX_STRIDE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .out_stall   (out_stall),
        .st          (st),
        .out_valid   (out_valid),
        .intensity   (intensity),
        .row_last    (row_last),
        .frame_last  (frame_last)
    );

endmodule

>>> src/spin_ctrl.sv
// ----------------------------------------------------------------------------
// spin_ctrl
// Sequencer: byte intake, row norm iterations, sample scaling and output load.
// ----------------------------------------------------------------------------
module spin_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  spin_pkg::stat_t st,
    output spin_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NDIV,
        S_NSQRT,
        S_NDONE,
        S_SMUL,
        S_SDIV,
        S_SOUT
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [spin_pkg::STEP_W-1:0] step_reg;
    logic [spin_pkg::STEP_W-1:0] step_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.step       = step_reg;
        cmd.accept     = in_valid && (state_reg == S_IDLE);
        cmd.ndiv_step  = (state_reg == S_NDIV);
        cmd.nsqrt_step = (state_reg == S_NSQRT);
        cmd.norm_load  = (state_reg == S_NDONE);
        cmd.samp_mul   = (state_reg == S_SMUL);
        cmd.sdiv_step  = (state_reg == S_SDIV);
        cmd.out_load   = (state_reg == S_SOUT) && !st.out_busy;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (cmd.accept && st.start_norm)
                begin
                    state_next = S_NDIV;
                end
                else if (cmd.accept && st.start_sample)
                begin
                    state_next = S_SMUL;
                end
            end
            S_NDIV:
            begin
                if (step_reg == spin_pkg::STEP_W'(spin_pkg::NDIV_STEPS - 1))
                begin
                    state_next = S_NSQRT;
                    step_next  = '0;
                end
            end
            S_NSQRT:
            begin
                if (step_reg == spin_pkg::STEP_W'(spin_pkg::NSQRT_STEPS - 1))
                begin
                    state_next = S_NDONE;
                end
            end
            S_NDONE:
            begin
                state_next = S_IDLE;
            end
            S_SMUL:
            begin
                state_next = S_SDIV;
                step_next  = '0;
            end
            S_SDIV:
            begin
                if (step_reg == spin_pkg::STEP_W'(spin_pkg::SDIV_STEPS - 1))
                begin
                    state_next = S_SOUT;
                end
            end
            S_SOUT:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_norm_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && st.start_norm |=> state_reg == S_NDIV)
        else $error("norm computation did not start");

    a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SOUT && !st.out_busy |=> state_reg == S_IDLE)
        else $error("result not handed to output register");

    a_ndiv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NDIV |-> step_reg < spin_pkg::STEP_W'(spin_pkg::NDIV_STEPS))
        else $error("divide step overrun");

    a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
        !(st.start_norm && st.start_sample))
        else $error("gain byte and sample byte at once");

endmodule

>>> src/spin_dp.sv
// ----------------------------------------------------------------------------
// spin_dp
// Datapath: row/byte counters, gain and sample assembly, iterative divide and
// square root for the row norm, sample scaling and the output register.
// ----------------------------------------------------------------------------
module spin_dp
#(
    parameter int MAX_BEARINGS = spin_pkg::DEF_MAX_BEARINGS,
    parameter int MAX_RANGES   = spin_pkg::DEF_MAX_RANGES,
    parameter int MAX_STRIDE   = spin_pkg::DEF_MAX_STRIDE
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  spin_pkg::cfg_t  cfg,
    input  spin_pkg::cmd_t  cmd,
    input  logic [7:0]      data_byte,
    input  logic            frame_start,
    input  logic            out_stall,
    output spin_pkg::stat_t st,
    output logic            out_valid,
    output logic [7:0]      intensity,
    output logic            row_last,
    output logic            frame_last
);

    localparam int SW_W  = $clog2(MAX_STRIDE + 1);
    localparam int LEN_W = (SW_W > 14) ? SW_W : 14;

    logic [LEN_W-1:0] byte_in_row_reg;
    logic [12:0]      row_index_reg;
    logic [31:0]      gain_reg;
    logic [31:0]      norm_reg;
    logic [31:0]      acc_reg;
    logic             row_last_reg;
    logic             frame_last_reg;
    logic [32:0]      rem_reg;
    logic [62:0]      quo_reg;
    logic [62:0]      root_reg;
    logic [62:0]      bit_reg;
    logic [7:0]       squo_reg;
    logic             out_valid_reg;
    logic [7:0]       intensity_reg;
    logic             row_last_out_reg;
    logic             frame_last_out_reg;

    logic [1:0]       sb_shift;
    logic [1:0]       kmax;
    logic [2:0]       hdr;
    logic [10:0]      bc;
    logic [12:0]      rc;
    logic [LEN_W-1:0] content;
    logic [LEN_W-1:0] stride_c;
    logic [LEN_W-1:0] stride;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] off;
    logic [12:0]      row0;
    logic [12:0]      row;
    logic [1:0]       k;
    logic             is_hdr;
    logic             is_samp;
    logic             samp_done;
    logic             row_last_n;
    logic             frame_last_n;
    logic [31:0]      acc_next;
    logic [32:0]      ntrial;
    logic [63:0]      sq_sum;
    logic [63:0]      prod;
    logic [39:0]      q16_scaled;
    logic [39:0]      q255;
    logic [71:0]      q32_scaled;
    logic [7:0]       squo_next;

    always_comb
    begin
        unique case (cfg.sample_width_code)
            spin_pkg::WCODE_16:
            begin
                sb_shift = 2'd1;
                kmax     = 2'd1;
            end
            spin_pkg::WCODE_32:
            begin
                sb_shift = 2'd2;
                kmax     = 2'd3;
            end
            default:
            begin
                sb_shift = 2'd0;
                kmax     = 2'd0;
            end
        endcase
    end

    assign hdr = cfg.gains_present ? 3'(spin_pkg::GAIN_BYTES) : 3'd0;
    assign bc  = (cfg.beam_count == '0) ? 11'd1 :
                 (32'(cfg.beam_count) > MAX_BEARINGS) ? 11'(MAX_BEARINGS) :
                 cfg.beam_count;
    assign rc  = (cfg.bin_count == '0) ? 13'd1 :
                 (32'(cfg.bin_count) > MAX_RANGES) ? 13'(MAX_RANGES) :
                 cfg.bin_count;
    assign content  = LEN_W'(hdr) + (LEN_W'(bc) << sb_shift);
    assign stride_c = (cfg.row_stride == '0) ? LEN_W'(1) :
                      (32'(cfg.row_stride) > MAX_STRIDE) ? LEN_W'(MAX_STRIDE) :
                      LEN_W'(cfg.row_stride);
    assign stride   = (stride_c < content) ? content : stride_c;

    assign pos     = frame_start ? '0 : byte_in_row_reg;
    assign row0    = frame_start ? '0 : row_index_reg;
    assign row     = (row0 >= rc) ? '0 : row0;
    assign is_hdr  = pos < LEN_W'(hdr);
    assign off     = pos - LEN_W'(hdr);
    assign k       = off[1:0] & kmax;
    assign is_samp = !is_hdr && (pos < content);
    assign samp_done    = is_samp && (k == kmax);
    assign row_last_n   = (pos == content - 1'b1);
    assign frame_last_n = row_last_n && (row == rc - 1'b1);

    assign st.start_norm   = cmd.accept && is_hdr && cfg.gain_compensation_on
                             && (pos == LEN_W'(spin_pkg::GAIN_BYTES - 1));
    assign st.start_sample = cmd.accept && samp_done;
    assign st.out_busy     = out_valid_reg && out_stall;

    always_comb
    begin
        acc_next = (k == 2'd0) ? 32'd0 : acc_reg;
        acc_next[{k, 3'b000} +: 8] = data_byte;
    end

    assign ntrial = {rem_reg[31:0], (cmd.step == '0)};
    assign sq_sum = {1'b0, root_reg} + {1'b0, bit_reg};
    assign prod   = acc_reg * norm_reg;

    // q / 257 for q below 2^16: (q * 65281) >> 24
    assign q16_scaled = {8'd0, rem_reg[15:0], 16'd0} - {16'd0, rem_reg[15:0], 8'd0}
                        + {24'd0, rem_reg[15:0]};
    // q / 16843009 for q below 2^32: (q * (255 * 2^32 + 256)) >> 64
    assign q255       = {rem_reg[31:0], 8'd0} - {8'd0, rem_reg[31:0]};
    assign q32_scaled = {q255, 32'd0} + {32'd0, rem_reg[31:0], 8'd0};

    always_comb
    begin
        unique case (cfg.sample_width_code)
            spin_pkg::WCODE_16: squo_next = q16_scaled[31:24];
            spin_pkg::WCODE_32: squo_next = q32_scaled[71:64];
            default:            squo_next = rem_reg[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            row_index_reg   <= '0;
            gain_reg        <= '0;
            norm_reg        <= spin_pkg::UNITY_NORM;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                if ({1'b0, pos} + 1'b1 >= {1'b0, stride})
                begin
                    byte_in_row_reg <= '0;
                    row_index_reg   <= (row + 1'b1 >= rc) ? '0 : row + 1'b1;
                end
                else
                begin
                    byte_in_row_reg <= pos + 1'b1;
                    row_index_reg   <= row;
                end
                if (pos == '0)
                begin
                    norm_reg <= spin_pkg::UNITY_NORM;
                end
                if (is_hdr)
                begin
                    gain_reg[{pos[1:0], 3'b000} +: 8] <= data_byte;
                end
                if (is_samp)
                begin
                    acc_reg <= acc_next;
                end
            end
            if (cmd.norm_load)
            begin
                norm_reg <= (gain_reg == '0) ? spin_pkg::UNITY_NORM :
                            (root_reg > 63'(spin_pkg::UNITY_NORM)) ? spin_pkg::UNITY_NORM :
                            root_reg[31:0];
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && samp_done)
        begin
            row_last_reg   <= row_last_n;
            frame_last_reg <= frame_last_n;
        end
        if (st.start_norm)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            root_reg <= '0;
            bit_reg  <= 63'(1) << 62;
        end
        if (cmd.ndiv_step)
        begin
            if (ntrial >= {1'b0, gain_reg})
            begin
                rem_reg <= ntrial - {1'b0, gain_reg};
                quo_reg <= {quo_reg[61:0], 1'b1};
            end
            else
            begin
                rem_reg <= ntrial;
                quo_reg <= {quo_reg[61:0], 1'b0};
            end
        end
        if (cmd.nsqrt_step)
        begin
            if ({1'b0, quo_reg} >= sq_sum)
            begin
                quo_reg  <= 63'({1'b0, quo_reg} - sq_sum);
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.samp_mul)
        begin
            rem_reg  <= {1'b0, prod[62:31]};
            squo_reg <= '0;
        end
        if (cmd.sdiv_step)
        begin
            squo_reg <= squo_next;
        end
        if (cmd.out_load)
        begin
            intensity_reg      <= (cfg.sample_width_code == spin_pkg::WCODE_NA) ? 8'd0 :
                                  squo_reg;
            row_last_out_reg   <= row_last_reg;
            frame_last_out_reg <= frame_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign intensity  = intensity_reg;
    assign row_last   = row_last_out_reg;
    assign frame_last = frame_last_out_reg;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sonar ping intensity normalizer core.
// Drives pings as byte beats over several register settings, predicts each
// bearing intensity with an in-bench fixed-point model and compares every
// output beat in order, with random idle cycles on both channels in the earlier phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       fs;
    } beat_t;

    typedef struct packed {
        logic [7:0] inten;
        logic       rlast;
        logic       flast;
    } pixel_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [spin_pkg::ADDR_W-1:0] paddr = '0;
    logic [spin_pkg::DATA_W-1:0] pwdata = '0;
    logic [spin_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [7:0]                  data_byte = '0;
    logic                        frame_start = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [7:0]                  intensity;
    logic                        row_last;
    logic                        frame_last;

    beat_t  beat_q[$];
    pixel_t pixel_q[$];
    int     errors = 0;
    int     send_idle_pct = 6;
    int     recv_stall_pct = 64;
    bit     beat_taken = 1'b0;

    logic [1:0]  m_wcode = spin_pkg::WCODE_8;
    logic        m_gains = 1'b0;
    logic        m_comp = 1'b0;
    logic [10:0] m_bearings = 11'd256;
    logic [12:0] m_ranges = 13'd512;
    logic [13:0] m_stride = 14'd260;
    int unsigned m_pos = 0;
    int unsigned m_row = 0;
    logic [31:0] m_gain = '0;
    logic [31:0] m_norm = spin_pkg::UNITY_NORM;
    logic [31:0] m_acc = '0;

    sonar_ping_intensity_normalizer_core uut (.*);

    always #10 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned clampv(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic int unsigned sample_bytes(input logic [1:0] code);
        return code == spin_pkg::WCODE_16 ? 2 : (code == spin_pkg::WCODE_32 ? 4 : 1);
    endfunction

    function automatic logic [31:0] norm_from_gain(input logic [31:0] g);
        longint unsigned v;
        longint unsigned r;
        longint unsigned t;
        if (g == 0) return spin_pkg::UNITY_NORM;
        v = (64'd1 << 62) / g;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        if (r > spin_pkg::UNITY_NORM) r = spin_pkg::UNITY_NORM;
        return r[31:0];
    endfunction

    function automatic void predict_pixel(input logic [7:0] d, input logic fs);
        int unsigned     sb;
        int unsigned     hdr;
        int unsigned     bc;
        int unsigned     rc;
        int unsigned     content;
        int unsigned     stride;
        int unsigned     off;
        int unsigned     k;
        int unsigned     b;
        longint unsigned q;
        pixel_t          px;
        sb = sample_bytes(m_wcode);
        hdr = m_gains ? spin_pkg::GAIN_BYTES : 0;
        bc = clampv(m_bearings, spin_pkg::DEF_MAX_BEARINGS);
        rc = clampv(m_ranges, spin_pkg::DEF_MAX_RANGES);
        content = hdr + bc * sb;
        stride = clampv(m_stride, spin_pkg::DEF_MAX_STRIDE);
        if (stride < content) stride = content;
        if (fs)
        begin
            m_pos = 0;
            m_row = 0;
        end
        if (m_row >= rc) m_row = 0;
        if (m_pos == 0) m_norm = spin_pkg::UNITY_NORM;
        if (m_pos < hdr)
        begin
            m_gain[8 * (m_pos % 4) +: 8] = d;
            if (m_pos == hdr - 1 && m_comp) m_norm = norm_from_gain(m_gain);
        end
        else if (m_pos < content)
        begin
            off = m_pos - hdr;
            k = off % sb;
            b = off / sb;
            if (k == 0) m_acc = '0;
            m_acc[8 * k +: 8] = d;
            if (k == sb - 1)
            begin
                px = '0;
                if (m_wcode != spin_pkg::WCODE_NA)
                begin
                    q = (64'(m_acc) * 64'(m_norm)) >> 31;
                    q = q / (sb == 1 ? 1 : (sb == 2 ? spin_pkg::DIV_16 : spin_pkg::DIV_32));
                    px.inten = q > 255 ? 8'd255 : q[7:0];
                end
                px.rlast = b == bc - 1;
                px.flast = b == bc - 1 && m_row == rc - 1;
                pixel_q.insert(pixel_q.size(), px);
            end
        end
        if (m_pos + 1 >= stride)
        begin
            m_pos = 0;
            m_row = m_row + 1 >= rc ? 0 : m_row + 1;
        end
        else
            m_pos = m_pos + 1;
    endfunction

    always @(posedge clk)
    begin
        beat_taken = in_valid && !in_stall;
        if (beat_taken) predict_pixel(data_byte, frame_start);
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                data_byte <= beat_q[0].data;
                frame_start <= beat_q[0].fs;
                void'(beat_q.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= $urandom_range(99) < recv_stall_pct;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
                report("output beat with nothing expected");
            else
            begin
                if (intensity !== pixel_q[0].inten)
                    report($sformatf("intensity %0d, expected %0d", intensity,
                        pixel_q[0].inten));
                if (row_last !== pixel_q[0].rlast)
                    report($sformatf("row_last %b, expected %b", row_last,
                        pixel_q[0].rlast));
                if (frame_last !== pixel_q[0].flast)
                    report($sformatf("frame_last %b, expected %b", frame_last,
                        pixel_q[0].flast));
                void'(pixel_q.pop_front());
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= spin_pkg::ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            spin_pkg::REG_SAMPLE_WIDTH: m_wcode = val[1:0];
            spin_pkg::REG_GAINS:        m_gains = val[0];
            spin_pkg::REG_COMP:         m_comp = val[0];
            spin_pkg::REG_BEARINGS:     m_bearings = val[10:0];
            spin_pkg::REG_RANGES:       m_ranges = val[12:0];
            spin_pkg::REG_STRIDE:       m_stride = val[13:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (beat_q.size() > 0 || in_valid || pixel_q.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    // fill exactly nbytes beats of pings; some cut short, some wrap without a frame mark
    task automatic load_pings(input int nbytes);
        int unsigned sb;
        int unsigned hdr;
        int unsigned bc;
        int unsigned rc;
        int unsigned content;
        int unsigned stride;
        int          sent;
        logic [31:0] g;
        bit          mark;
        beat_t       bt;
        sb = sample_bytes(m_wcode);
        hdr = m_gains ? spin_pkg::GAIN_BYTES : 0;
        bc = clampv(m_bearings, spin_pkg::DEF_MAX_BEARINGS);
        rc = clampv(m_ranges, spin_pkg::DEF_MAX_RANGES);
        content = hdr + bc * sb;
        stride = clampv(m_stride, spin_pkg::DEF_MAX_STRIDE);
        if (stride < content) stride = content;
        sent = 0;
        mark = 1'b1;
        while (sent < nbytes)
        begin
            for (int r = 0; r < rc && sent < nbytes; r++)
            begin
                g = pick_gain();
                for (int p = 0; p < stride && sent < nbytes; p++)
                begin
                    bt.fs = mark || $urandom_range(199) == 0;
                    mark = 1'b0;
                    bt.data = p < hdr ? g[8 * (p % 4) +: 8] : 8'($urandom);
                    if (p >= hdr && $urandom_range(7) == 0)
                        bt.data = $urandom_range(1) ? 8'hFF : 8'h00;
                    beat_q.insert(beat_q.size(), bt);
                    sent++;
                end
            end
            mark = $urandom_range(3) != 0;
        end
    endtask

    task automatic run_phase(input int ph, input logic [1:0] wc, input bit gp, input bit gc,
                             input logic [10:0] bc, input logic [12:0] rc,
                             input logic [13:0] st, input int nbytes);
        send_idle_pct = ph < 6 ? 6 : (ph < 12 ? 64 : 0);
        recv_stall_pct = ph < 6 ? 64 : (ph < 12 ? 6 : 0);
        write_reg(spin_pkg::REG_SAMPLE_WIDTH, 32'(wc));
        write_reg(spin_pkg::REG_GAINS, 32'(gp));
        write_reg(spin_pkg::REG_COMP, 32'(gc));
        write_reg(spin_pkg::REG_BEARINGS, 32'(bc));
        write_reg(spin_pkg::REG_RANGES, 32'(rc));
        write_reg(spin_pkg::REG_STRIDE, 32'(st));
        load_pings(nbytes);
        drain();
    endtask

    initial
    begin
        logic [1:0] wc;
        int unsigned bc;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        beat_q.insert(beat_q.size(), '{8'h00, 1'b1});
        beat_q.insert(beat_q.size(), '{8'hFF, 1'b0});
        beat_q.insert(beat_q.size(), '{8'h80, 1'b0});
        beat_q.insert(beat_q.size(), '{8'h01, 1'b0});
        drain();
        run_phase(0, spin_pkg::WCODE_8, 1'b0, 1'b0, 11'd4, 13'd2, 14'd5, 20);
        run_phase(1, spin_pkg::WCODE_32, 1'b1, 1'b1, 11'd2, 13'd2, 14'd0, 60);
        run_phase(2, spin_pkg::WCODE_NA, 1'b1, 1'b1, 11'd0, 13'd0, 14'd0, 30);
        run_phase(3, spin_pkg::WCODE_32, 1'b1, 1'b1, 11'h7FF, 13'h1FFF, 14'h3FFF, 300);
        for (int ph = 4; ph < 18; ph++)
        begin
            wc = 2'($urandom_range(3));
            bc = $urandom_range(6, 1);
            run_phase(ph, wc, 1'($urandom_range(1)), $urandom_range(3) != 0, 11'(bc),
                13'($urandom_range(4, 1)), 14'($urandom_range(bc * 4 + 10)), 70);
            if (ph == 8)
            begin
                load_pings(30);
                drain();
            end
        end
        drain();
        if (pixel_q.size() != 0)
            report("expected output beats never arrived");
        if (errors == 0)
            $display("sonar_ping_intensity_normalizer_core verification clean");
        else
            $display("sonar_ping_intensity_normalizer_core verification failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("sonar_ping_intensity_normalizer_core verification failed");
        $finish;
    end
endmodule
